>>> hw/rtl/ssm_pkg.sv
`timescale 1ns / 1ps

package ssm_pkg;

   // Transaction opcodes
   localparam logic [1:0] OP_LOAD_PATTERN = 2'd0;
   localparam logic [1:0] OP_LOAD_SUBJECT = 2'd1;
   localparam logic [1:0] OP_COMPARE      = 2'd2;

   // Match modes
   localparam logic [1:0] MODE_EQUAL   = 2'd0;
   localparam logic [1:0] MODE_INITIAL = 2'd1;
   localparam logic [1:0] MODE_FINAL   = 2'd2;
   localparam logic [1:0] MODE_ANY     = 2'd3;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] byte_value;
      logic [1:0] match_mode;
      logic       case_ignore;
   } req_type;

   typedef struct packed {
      logic matched;
      logic overflowed;
   } rsp_type;

   function automatic logic is_lower(input logic [7:0] c);
      return (c >= 8'h61) && (c <= 8'h7A);
   endfunction

   // Byte equality, optionally folding ASCII letter case
   function automatic logic bytes_match(input logic [7:0] a, input logic [7:0] b,
                                        input logic fold);
      logic [8:0] a_ext;
      logic [8:0] b_ext;
      a_ext = {1'b0, a};
      b_ext = {1'b0, b};
      if (a == b) begin
         return 1'b1;
      end
      if (!fold) begin
         return 1'b0;
      end
      if (is_lower(a) && (a_ext == b_ext + 9'd32)) begin
         return 1'b1;
      end
      if (is_lower(b) && (b_ext == a_ext + 9'd32)) begin
         return 1'b1;
      end
      return 1'b0;
   endfunction

endpackage

>>> hw/rtl/string_substring_matcher_top.sv
`timescale 1ns / 1ps

// String substring matcher. Pattern and subject bytes are appended to two
// on-chip stores of MAX_LEN bytes each by load transactions, which can be
// taken back to back and return nothing. A compare transaction matches the
// pattern against the subject in equal, initial, final or any-offset mode,
// with optional ASCII case folding, returns one response and clears both
// stores' counts and the overflow flag. Bytes loaded into a full store are
// dropped and flagged; such a compare reports no match. A compare is run by
// a small sequencer around one byte comparator fed by the registered read
// ports of the two stores: each byte comparison has an address step, then a
// compare step. Equal, initial and final modes walk the pattern at a single
// offset; any mode is a naive sliding search, stopping at the first mismatch
// of each offset and at the first hit. Compares settled by the lengths, by
// an overflow or by an empty pattern skip the byte walk. Requests are
// stalled while a compare runs; loads are taken while a response waits on
// rsp_stall.
module string_substring_matcher_top #(
   parameter int MAX_LEN = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ssm_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ssm_pkg::rsp_type rsp_payload
);

   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] pattern_count_ff, pattern_count_in;
   logic [CNT_W-1:0] subject_count_ff, subject_count_in;
   logic             overflow_ff, overflow_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] off_ff, off_in;
   logic [IDX_W-1:0] last_off_ff, last_off_in;
   logic             fold_ff, fold_in;
   logic             result_ff, result_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ssm_pkg::rsp_type rsp_payload_ff, rsp_payload_in;

   // Byte stores with registered read ports
   logic [7:0]       pattern_mem [MAX_LEN];
   logic [7:0]       subject_mem [MAX_LEN];
   logic [7:0]       pattern_rd_ff;
   logic [7:0]       subject_rd_ff;

   logic             req_fire;
   logic             pattern_we;
   logic             subject_we;
   logic             pattern_full;
   logic             subject_full;
   logic [IDX_W-1:0] subject_addr;
   logic [CNT_W-1:0] span;
   logic             last_idx;
   logic             byte_hit;

   // Accept requests only between compares
   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;

   assign pattern_full = (pattern_count_ff >= CNT_W'(MAX_LEN));
   assign subject_full = (subject_count_ff >= CNT_W'(MAX_LEN));
   assign pattern_we   = req_fire && (req_payload.opcode == ssm_pkg::OP_LOAD_PATTERN)
                         && !pattern_full;
   assign subject_we   = req_fire && (req_payload.opcode == ssm_pkg::OP_LOAD_SUBJECT)
                         && !subject_full;

   // Subject position of the current pattern byte; stays below subject count
   assign subject_addr = off_ff + idx_ff;
   assign span         = subject_count_ff - pattern_count_ff;
   assign last_idx     = ((CNT_W'(idx_ff) + CNT_W'(1)) == pattern_count_ff);
   assign byte_hit     = ssm_pkg::bytes_match(pattern_rd_ff, subject_rd_ff, fold_ff);

   always_ff @(posedge clock) begin
      if (pattern_we) begin
         pattern_mem[pattern_count_ff[IDX_W-1:0]] <= req_payload.byte_value;
      end
      pattern_rd_ff <= pattern_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (subject_we) begin
         subject_mem[subject_count_ff[IDX_W-1:0]] <= req_payload.byte_value;
      end
      subject_rd_ff <= subject_mem[subject_addr];
   end

   always_comb begin
      state_in         = state_ff;
      pattern_count_in = pattern_count_ff;
      subject_count_in = subject_count_ff;
      overflow_in      = overflow_ff;
      idx_in           = idx_ff;
      off_in           = off_ff;
      last_off_in      = last_off_ff;
      fold_in          = fold_ff;
      result_in        = result_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_payload_in   = rsp_payload_ff;

      // Drop the response once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_payload.opcode)
                  ssm_pkg::OP_LOAD_PATTERN: begin
                     if (pattern_full) begin
                        overflow_in = 1'b1;
                     end else begin
                        pattern_count_in = pattern_count_ff + CNT_W'(1);
                     end
                  end
                  ssm_pkg::OP_LOAD_SUBJECT: begin
                     if (subject_full) begin
                        overflow_in = 1'b1;
                     end else begin
                        subject_count_in = subject_count_ff + CNT_W'(1);
                     end
                  end
                  ssm_pkg::OP_COMPARE: begin
                     fold_in = req_payload.case_ignore;
                     idx_in  = '0;
                     if (overflow_ff || (pattern_count_ff > subject_count_ff) ||
                         ((req_payload.match_mode == ssm_pkg::MODE_EQUAL) &&
                          (pattern_count_ff != subject_count_ff))) begin
                        // Settled by the lengths or by an overflow
                        result_in = 1'b0;
                        state_in  = ST_DONE;
                     end else if (pattern_count_ff == '0) begin
                        // Empty pattern matches (equal mode: both empty)
                        result_in = 1'b1;
                        state_in  = ST_DONE;
                     end else begin
                        case (req_payload.match_mode)
                           ssm_pkg::MODE_FINAL: begin
                              off_in      = span[IDX_W-1:0];
                              last_off_in = span[IDX_W-1:0];
                           end
                           ssm_pkg::MODE_ANY: begin
                              off_in      = '0;
                              last_off_in = span[IDX_W-1:0];
                           end
                           default: begin
                              off_in      = '0;
                              last_off_in = '0;
                           end
                        endcase
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     // Unused opcode: take the transaction and do nothing
                  end
               endcase
            end
         end
         ST_READ: begin
            // Stores capture the addressed bytes at this edge
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (byte_hit) begin
               if (last_idx) begin
                  result_in = 1'b1;
                  state_in  = ST_DONE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_READ;
               end
            end else if (off_ff == last_off_ff) begin
               result_in = 1'b0;
               state_in  = ST_DONE;
            end else begin
               // Slide to the next offset and restart the pattern
               off_in   = off_ff + IDX_W'(1);
               idx_in   = '0;
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            // Hold the result until the response register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_payload_in.matched    = result_ff;
               rsp_payload_in.overflowed = overflow_ff;
               pattern_count_in          = '0;
               subject_count_in          = '0;
               overflow_in               = 1'b0;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         pattern_count_ff <= '0;
         subject_count_ff <= '0;
         overflow_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         pattern_count_ff <= pattern_count_in;
         subject_count_ff <= subject_count_in;
         overflow_ff      <= overflow_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      idx_ff         <= idx_in;
      off_ff         <= off_in;
      last_off_ff    <= last_off_in;
      fold_ff        <= fold_in;
      result_ff      <= result_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   // Pattern index stays inside the loaded pattern during a walk
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (CNT_W'(idx_ff) < pattern_count_ff))
      else $error("pattern index beyond pattern count");

   // Subject reads stay inside the loaded subject
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |->
         ((CNT_W'(off_ff) + CNT_W'(idx_ff)) < subject_count_ff))
      else $error("subject read beyond subject count");

   // Offset never passes the last offset of the search
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_READ) || (state_ff == ST_CHECK)) |-> (off_ff <= last_off_ff))
      else $error("search offset past last offset");

   // Leaving a compare clears both counts and the overflow flag
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && (state_in == ST_IDLE)) |=>
         ((pattern_count_ff == '0) && (subject_count_ff == '0) && !overflow_ff
          && rsp_valid_ff))
      else $error("compare did not clear state or post a response");

   // An overflowed compare never reports a match
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_payload_ff.matched && rsp_payload_ff.overflowed))
      else $error("match reported after overflow");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int          STORE_DEPTH = 256;
   localparam int unsigned CYCLE_LIMIT = 400000;
   // the package names three opcodes only; the fourth must be ignored
   localparam logic [1:0]  OP_UNUSED   = 2'd3;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   ssm_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   ssm_pkg::rsp_type rsp_payload;

   // 8 ns period
   always #4 clock = ~clock;

   string_substring_matcher_top #(
      .MAX_LEN(STORE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   // ---------------------------------------------------------------------
   // Shadow of the matcher: both byte stores, their fill levels and the
   // sticky overflow flag, updated as each request transaction is accepted.
   // ---------------------------------------------------------------------
   logic [7:0]       shadow_pattern [STORE_DEPTH];
   logic [7:0]       shadow_subject [STORE_DEPTH];
   int unsigned      shadow_pat_len  = 0;
   int unsigned      shadow_sub_len  = 0;
   logic             shadow_overflow = 1'b0;

   ssm_pkg::rsp_type expected_verdicts [$];
   ssm_pkg::req_type req_backlog [$];
   ssm_pkg::rsp_type oldest_verdict;

   int               mismatch_count = 0;
   int               items_queued   = 0;
   int unsigned      cycle_count    = 0;
   int               send_idle_pct  = 0;
   int               recv_stall_pct = 0;

   // stimulus scratch: bytes of the next pattern and subject to load
   logic [7:0]       pat_bytes [$];
   logic [7:0]       sub_bytes [$];

   function automatic logic ascii_letter(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   // Same byte, or the same letter in the other case when folding is on.
   // Upper and lower case letters differ in bit 5 alone.
   function automatic logic chars_agree(input logic [7:0] a, input logic [7:0] b,
                                        input logic fold);
      if (a == b) begin
         return 1'b1;
      end
      return fold && ascii_letter(a) && ascii_letter(b) && ((a ^ b) == 8'h20);
   endfunction

   function automatic logic pattern_fits_at(input int unsigned offset, input logic fold);
      for (int unsigned i = 0; i < shadow_pat_len; i++) begin
         if (!chars_agree(shadow_pattern[i], shadow_subject[offset + i], fold)) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic logic match_verdict(input logic [1:0] mode, input logic fold);
      // a pattern longer than the subject can never match
      if (shadow_pat_len > shadow_sub_len) begin
         return 1'b0;
      end
      case (mode)
         ssm_pkg::MODE_EQUAL: begin
            return (shadow_pat_len == shadow_sub_len) && pattern_fits_at(0, fold);
         end
         ssm_pkg::MODE_INITIAL: begin
            return pattern_fits_at(0, fold);
         end
         ssm_pkg::MODE_FINAL: begin
            return pattern_fits_at(shadow_sub_len - shadow_pat_len, fold);
         end
         default: begin
            // sliding search; an empty pattern hits at offset zero
            for (int unsigned off = 0; off <= shadow_sub_len - shadow_pat_len; off++) begin
               if (pattern_fits_at(off, fold)) begin
                  return 1'b1;
               end
            end
            return 1'b0;
         end
      endcase
   endfunction

   // Apply one accepted request transaction to the shadow state and queue
   // the verdict a compare must produce.
   task automatic predict_match(input ssm_pkg::req_type item);
      ssm_pkg::rsp_type verdict;
      case (item.opcode)
         ssm_pkg::OP_LOAD_PATTERN: begin
            if (shadow_pat_len < STORE_DEPTH) begin
               shadow_pattern[shadow_pat_len] = item.byte_value;
               shadow_pat_len++;
            end else begin
               shadow_overflow = 1'b1;
            end
         end
         ssm_pkg::OP_LOAD_SUBJECT: begin
            if (shadow_sub_len < STORE_DEPTH) begin
               shadow_subject[shadow_sub_len] = item.byte_value;
               shadow_sub_len++;
            end else begin
               shadow_overflow = 1'b1;
            end
         end
         ssm_pkg::OP_COMPARE: begin
            verdict.overflowed = shadow_overflow;
            verdict.matched    = shadow_overflow ? 1'b0
                                 : match_verdict(item.match_mode, item.case_ignore);
            expected_verdicts.push_back(verdict);
            shadow_pat_len  = 0;
            shadow_sub_len  = 0;
            shadow_overflow = 1'b0;
         end
         default: begin
            // unused opcode: no state change, no response
         end
      endcase
   endtask

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("%0t ns: MISMATCH %s", $time, msg);
   endtask

   // ---------------------------------------------------------------------
   // Driver: at every edge where the held transaction is taken (or none is
   // held), either present the next backlog entry or go idle, as the
   // current sender idle rate decides. A stalled transaction is held as is.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_match(req_payload);
         end
         if (!req_valid || !req_stall) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_payload <= req_backlog.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid   <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: stall at the current receiver rate and check every accepted
   // response transaction against the oldest predicted verdict.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch($sformatf("response %b with no compare outstanding",
                                         rsp_payload));
            end else begin
               oldest_verdict = expected_verdicts.pop_front();
               if (rsp_payload.matched !== oldest_verdict.matched) begin
                  report_mismatch($sformatf("matched: got %b, expected %b",
                                            rsp_payload.matched, oldest_verdict.matched));
               end
               if (rsp_payload.overflowed !== oldest_verdict.overflowed) begin
                  report_mismatch($sformatf("overflowed: got %b, expected %b",
                                            rsp_payload.overflowed,
                                            oldest_verdict.overflowed));
               end
            end
         end
      end
   end

   // Watchdog: a lost response or a hung compare ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("string_substring_matcher_top verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus construction
   // ---------------------------------------------------------------------
   task automatic push_req(input logic [1:0] op, input logic [7:0] value,
                           input logic [1:0] mode, input logic fold);
      ssm_pkg::req_type item;
      item.opcode      = op;
      item.byte_value  = value;
      item.match_mode  = mode;
      item.case_ignore = fold;
      req_backlog.push_back(item);
      if (op != OP_UNUSED) begin
         items_queued++;
      end
   endtask

   // Mostly a small alphabet so that matches and near misses are common,
   // with the letter boundaries and the odd full-range byte mixed in.
   function automatic logic [7:0] pick_char();
      logic [7:0] edge_chars [6];
      int         roll;
      edge_chars = '{8'h7A, 8'h5A, 8'h40, 8'h5B, 8'h60, 8'h7B};
      roll = $urandom_range(99);
      if (roll < 60) begin
         case ($urandom_range(3))
            0:       return 8'h61;
            1:       return 8'h41;
            2:       return 8'h62;
            default: return 8'h42;
         endcase
      end else if (roll < 75) begin
         return edge_chars[$urandom_range(5)];
      end
      return 8'($urandom_range(255));
   endfunction

   // Interleave the loads of both stores at random (each store keeps its own
   // order), sprinkle in unused opcodes, then close with the compare.
   task automatic queue_case(input logic [1:0] mode, input logic fold);
      int pi;
      int si;
      pi = 0;
      si = 0;
      while (pi < pat_bytes.size() || si < sub_bytes.size()) begin
         if ($urandom_range(99) < 4) begin
            push_req(OP_UNUSED, 8'($urandom_range(255)), 2'($urandom_range(3)),
                     1'($urandom_range(1)));
         end
         if (si >= sub_bytes.size() || (pi < pat_bytes.size() && $urandom_range(1) == 1)) begin
            push_req(ssm_pkg::OP_LOAD_PATTERN, pat_bytes[pi], 2'($urandom_range(3)),
                     1'($urandom_range(1)));
            pi++;
         end else begin
            push_req(ssm_pkg::OP_LOAD_SUBJECT, sub_bytes[si], 2'($urandom_range(3)),
                     1'($urandom_range(1)));
            si++;
         end
      end
      push_req(ssm_pkg::OP_COMPARE, 8'($urandom_range(255)), mode, fold);
      pat_bytes.delete();
      sub_bytes.delete();
   endtask

   // Lift the pattern out of the subject at the place the mode looks, flip
   // the case of some letters and now and then spoil a byte.
   task automatic lift_pattern(input int p_len, input int offset);
      logic [7:0] c;
      for (int i = 0; i < p_len; i++) begin
         c = sub_bytes[offset + i];
         if (ascii_letter(c) && $urandom_range(2) == 0) begin
            c = c ^ 8'h20;
         end
         if ($urandom_range(24) == 0) begin
            c = pick_char();
         end
         pat_bytes.push_back(c);
      end
   endtask

   task automatic queue_random_case();
      int         p_len;
      int         s_len;
      int         offset;
      logic [1:0] mode;
      logic       fold;
      s_len = $urandom_range(12);
      p_len = $urandom_range(5);
      mode  = 2'($urandom_range(3));
      fold  = 1'($urandom_range(1));
      for (int i = 0; i < s_len; i++) begin
         sub_bytes.push_back(pick_char());
      end
      if (p_len <= s_len && $urandom_range(99) < 65) begin
         case (mode)
            ssm_pkg::MODE_EQUAL: begin
               p_len  = s_len;
               offset = 0;
            end
            ssm_pkg::MODE_INITIAL: offset = 0;
            ssm_pkg::MODE_FINAL:   offset = s_len - p_len;
            default:               offset = $urandom_range(s_len - p_len);
         endcase
         lift_pattern(p_len, offset);
      end else begin
         for (int i = 0; i < p_len; i++) begin
            pat_bytes.push_back(pick_char());
         end
      end
      queue_case(mode, fold);
   endtask

   // One big case per phase: full stores, overflow of either store, and a
   // long sliding search.
   task automatic queue_large_case(input int variant);
      int s_len;
      case (variant)
         0: begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
               sub_bytes.push_back(pick_char());
            end
            lift_pattern(STORE_DEPTH, 0);
            queue_case(ssm_pkg::MODE_EQUAL, 1'b1);
         end
         1: begin
            s_len = STORE_DEPTH + 1 + $urandom_range(2);
            for (int i = 0; i < s_len; i++) begin
               sub_bytes.push_back(pick_char());
            end
            lift_pattern(3, 0);
            queue_case(ssm_pkg::MODE_ANY, 1'($urandom_range(1)));
         end
         2: begin
            for (int i = 0; i < STORE_DEPTH + 1 + $urandom_range(2); i++) begin
               pat_bytes.push_back(pick_char());
            end
            for (int i = 0; i < 5; i++) begin
               sub_bytes.push_back(pick_char());
            end
            queue_case(2'($urandom_range(3)), 1'($urandom_range(1)));
         end
         default: begin
            for (int i = 0; i < 120; i++) begin
               sub_bytes.push_back(pick_char());
            end
            lift_pattern(20, 100);
            queue_case(ssm_pkg::MODE_ANY, 1'b1);
         end
      endcase
   endtask

   // Hold until every queued transaction is taken and every verdict is in.
   task automatic wait_until_drained();
      do begin
         @(negedge clock);
      end while (req_backlog.size() != 0 || req_valid || expected_verdicts.size() != 0);
   endtask

   task automatic set_idling(input int phase);
      case (phase)
         0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1:       begin send_idle_pct = 59; recv_stall_pct = 0;  end
         2:       begin send_idle_pct = 0;  recv_stall_pct = 59; end
         default: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
      endcase
   endtask

   initial begin
      int budget;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed cases, no idling.
      // empty pattern against empty subject, sliding search: hit
      queue_case(ssm_pkg::MODE_ANY, 1'b0);
      // unused opcode, all ones: dropped without a response
      push_req(OP_UNUSED, 8'hFF, ssm_pkg::MODE_ANY, 1'b1);
      // 'z' against 'Z' with case folding, equal mode: hit
      pat_bytes = '{8'h7A};
      sub_bytes = '{8'h5A};
      queue_case(ssm_pkg::MODE_EQUAL, 1'b1);
      // byte 0x00 at the tail of {0xFF, 0x00}, final mode: hit
      pat_bytes = '{8'h00};
      sub_bytes = '{8'hFF, 8'h00};
      queue_case(ssm_pkg::MODE_FINAL, 1'b0);
      // '@' '[' against '`' '{': bit 5 apart but not letters, so no fold
      pat_bytes = '{8'h40, 8'h5B};
      sub_bytes = '{8'h60, 8'h7B};
      queue_case(ssm_pkg::MODE_INITIAL, 1'b1);
      // pattern longer than subject: miss
      pat_bytes = '{8'h61, 8'h62};
      sub_bytes = '{8'h62};
      queue_case(ssm_pkg::MODE_ANY, 1'b1);
      // empty pattern, equal mode, lengths differ: miss
      sub_bytes = '{8'hFF};
      queue_case(ssm_pkg::MODE_EQUAL, 1'b0);
      // empty pattern, initial mode: hit
      sub_bytes = '{8'h41};
      queue_case(ssm_pkg::MODE_INITIAL, 1'b0);
      // hold the sender until every verdict is back
      wait_until_drained();

      // Random phases, each with its own idling pattern.
      for (int phase = 0; phase < 4; phase++) begin
         set_idling(phase);
         queue_large_case(phase);
         budget = items_queued + 110;
         while (items_queued < budget) begin
            queue_random_case();
         end
         wait_until_drained();
      end

      // let any stray response show up before the verdict
      repeat (40) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("string_substring_matcher_top verification clean");
      end else begin
         $display("string_substring_matcher_top verification failed");
      end
      $finish;
   end

endmodule
